FILE: src/lsr_pkg.sv
// Shared types and constants for the line segment rasterizer.
package lsr_pkg;

    // Width of one grid coordinate on the ports.
    localparam int COORD_W = 5;

    // One segment request: two endpoints.
    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } t_in_item;

    // One pixel of the drawn segment.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new segment
        logic div_go;    // start the slope division
        logic slope_ld;  // register the signed slope
        logic acc_ld;    // set up the accumulator for the pass
        logic step;      // emit one pixel and advance
        logic pass_y;    // 0: X-axis pass, 1: Y-axis pass
        logic last;      // mark the emitted pixel as the final one
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_idle;  // divider has no division in flight
        logic pass_end;  // current index is the last one of the pass
        logic out_free;  // output register can take a pixel this cycle
    } t_sts;

endpackage

FILE: src/lsr_div.sv
// Restoring bit-serial divider that returns a rounded fixed-point slope magnitude.
module lsr_div import lsr_pkg::*; #(
    parameter int FRAC = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [COORD_W-1:0]  i_num,
    input  logic [COORD_W-1:0]  i_den,
    output logic                o_idle,
    output logic [FRAC+5:0]     o_mag
);

    // The dividend is num shifted left by FRAC+1, so the quotient carries one extra bit
    // that is used to round the magnitude half away from zero.
    localparam int DW = COORD_W + FRAC + 1;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]      r_cnt;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_den;
    logic [DW-1:0]      r_dq;

    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               fits;
    logic [DW:0]        rounded;

    // One quotient bit per cycle.
    assign trial = {r_rem, r_dq[DW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    // Control: the count of quotient bits still to produce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: remainder and the shifting dividend/quotient word.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_den <= i_den;
            r_dq  <= {i_num, {(FRAC + 1){1'b0}}};
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            r_dq  <= {r_dq[DW-2:0], fits};
        end
    end

    // Drop the extra quotient bit with rounding.
    assign rounded = {1'b0, r_dq} + (DW + 1)'(1);
    assign o_mag   = rounded[DW:1];
    assign o_idle  = (r_cnt == '0);

endmodule

FILE: src/lsr_datapath.sv
// Datapath: endpoint registers, slope, DDA accumulator and output register.
module lsr_datapath import lsr_pkg::*; #(
    parameter int GRID = 32,
    parameter int FRAC = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int SW = FRAC + 6;          // signed slope width
    localparam int AW = FRAC + 12;         // signed accumulator width
    localparam int IW = AW - FRAC;         // integer part of the accumulator
    localparam logic [COORD_W-1:0] MAXC = COORD_W'(GRID - 1);
    localparam logic signed [AW-1:0] HALF = {{(AW - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

    logic [COORD_W-1:0]  r_xs, r_ys, r_xe, r_ye;
    logic signed [SW-1:0] r_slope;
    logic signed [AW-1:0] r_acc;
    logic [COORD_W-1:0]  r_idx, r_hi;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [COORD_W-1:0]  cx_s, cy_s, cx_e, cy_e;
    logic signed [COORD_W:0] dx, dy, d_num, d_den;
    logic [COORD_W-1:0]  abs_num, abs_den;
    logic [SW-1:0]       mag;
    logic                div_idle;
    logic signed [SW-1:0] slope_n;
    logic [COORD_W-1:0]  a_pt, b_pt, base_pt, lo, hi;
    logic signed [COORD_W:0] off0;
    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] base_fx;
    logic [IW-1:0]       ipart;
    logic [COORD_W-1:0]  coord;
    logic                out_free;

    // Saturate endpoints that lie beyond the grid.
    assign cx_s = (i_in_item.x_start > MAXC) ? MAXC : i_in_item.x_start;
    assign cy_s = (i_in_item.y_start > MAXC) ? MAXC : i_in_item.y_start;
    assign cx_e = (i_in_item.x_end > MAXC) ? MAXC : i_in_item.x_end;
    assign cy_e = (i_in_item.y_end > MAXC) ? MAXC : i_in_item.y_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs <= cx_s;
            r_ys <= cy_s;
            r_xe <= cx_e;
            r_ye <= cy_e;
        end
    end

    // Slope operands: dy/dx for the X pass, dx/dy for the Y pass.
    assign dx      = $signed({1'b0, r_xe}) - $signed({1'b0, r_xs});
    assign dy      = $signed({1'b0, r_ye}) - $signed({1'b0, r_ys});
    assign d_num   = i_cmd.pass_y ? dx : dy;
    assign d_den   = i_cmd.pass_y ? dy : dx;
    assign abs_num = d_num[COORD_W] ? COORD_W'(-d_num) : d_num[COORD_W-1:0];
    assign abs_den = d_den[COORD_W] ? COORD_W'(-d_den) : d_den[COORD_W-1:0];

    lsr_div #(
        .FRAC (FRAC)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (abs_num),
        .i_den   (abs_den),
        .o_idle  (div_idle),
        .o_mag   (mag)
    );

    // Apply the sign; a zero divisor gives a flat slope.
    always_comb begin
        if (abs_den == '0) begin
            slope_n = '0;
        end else if (d_num[COORD_W] ^ d_den[COORD_W]) begin
            slope_n = -$signed(mag);
        end else begin
            slope_n = $signed(mag);
        end
    end

    // Pass setup: walk from the smaller to the larger coordinate.
    assign a_pt    = i_cmd.pass_y ? r_ys : r_xs;
    assign b_pt    = i_cmd.pass_y ? r_ye : r_xe;
    assign base_pt = i_cmd.pass_y ? r_xs : r_ys;
    assign lo      = (a_pt < b_pt) ? a_pt : b_pt;
    assign hi      = (a_pt < b_pt) ? b_pt : a_pt;
    assign off0    = $signed({1'b0, lo}) - $signed({1'b0, a_pt});
    assign prod    = AW'(r_slope) * AW'(off0);
    assign base_fx = $signed({{(AW - COORD_W - FRAC){1'b0}}, base_pt, {FRAC{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.slope_ld) begin
            r_slope <= slope_n;
        end
        if (i_cmd.acc_ld) begin
            r_acc <= prod + base_fx + HALF;
            r_idx <= lo;
            r_hi  <= hi;
        end else if (i_cmd.step) begin
            r_acc <= r_acc + {{(AW - SW){r_slope[SW-1]}}, r_slope};
            r_idx <= r_idx + 1'b1;
        end
    end

    // Floor of the accumulator, clamped to the grid.
    assign ipart = r_acc[AW-1:FRAC];
    always_comb begin
        if (ipart[IW-1]) begin
            coord = '0;
        end else if (ipart > IW'(GRID - 1)) begin
            coord = MAXC;
        end else begin
            coord = ipart[COORD_W-1:0];
        end
    end

    // Output register: holds one pixel until the receiver takes it.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out.pixel_x    <= i_cmd.pass_y ? coord : r_idx;
            r_out.pixel_y    <= i_cmd.pass_y ? r_idx : coord;
            r_out.last_pixel <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;
    assign o_sts.div_idle = div_idle;
    assign o_sts.pass_end = (r_idx == r_hi);
    assign o_sts.out_free = out_free;

endmodule

FILE: src/lsr_ctrl.sv
// Controller: sequences the division, pass setup and pixel emission of each segment.
module lsr_ctrl import lsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SLOPE,
        S_INIT,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_pass_y;

    // State register and pass select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass_y <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state  <= S_DIV_GO;
                        r_pass_y <= 1'b0;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_sts.div_idle) begin
                        r_state <= S_SLOPE;
                    end
                end
                S_SLOPE: begin
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (i_sts.out_free && i_sts.pass_end) begin
                        if (r_pass_y) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state  <= S_DIV_GO;
                            r_pass_y <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.pass_y   = r_pass_y;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_go   = (r_state == S_DIV_GO);
        o_cmd.slope_ld = (r_state == S_SLOPE);
        o_cmd.acc_ld   = (r_state == S_INIT);
        o_cmd.step     = (r_state == S_RUN) && i_sts.out_free;
        o_cmd.last     = r_pass_y && i_sts.pass_end;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: src/line_segment_rasterizer_top.sv
// Top level of the line segment rasterizer.
//
// Usage: a segment request (two endpoints on a GRID x GRID grid) enters on the
// i_in_valid / o_in_ready channel. The block draws it in two passes, one pixel
// per column from the smaller to the larger x, then one pixel per row from the
// smaller to the larger y, and sends each pixel on the o_out_valid / i_out_ready
// channel. The final pixel of a segment carries last_pixel.
// Timing: each pass starts with a bit-serial slope division, then the slope and
// accumulator setup states, then emits one pixel per cycle while the receiver
// accepts them. The first pixel appears after the first division and its setup.
// One segment is processed at a time; a new request is taken once the final
// pixel sits in the output register, even while the receiver still holds it.
// When the receiver stalls, the current pixel is held and the pass pauses.
// Reset clears the controller and output valid; no request is pending after it.
module line_segment_rasterizer_top import lsr_pkg::*; #(
    parameter int GRID = 32,
    parameter int FRAC = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing.
    lsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register.
    lsr_datapath #(
        .GRID (GRID),
        .FRAC (FRAC)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
